// ===== design/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared constants and types of the button click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int KIND_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_PRESSED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLICK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DOUBLE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LONG     = 3'd4;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_DOUBLE   = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd300;

  typedef struct packed {
    logic [CFG_W-1:0] settle_time;
    logic [CFG_W-1:0] long_limit;
    logic [CFG_W-1:0] pair_window;
  } bcc_cfg_t;

  typedef struct packed {
    logic              button_res;
    logic [KIND_W-1:0] event_kind;
    logic [TIME_W-1:0] hold_ms;
    logic              last;
  } bcc_res_t;

  typedef struct packed {
    logic [1:0] num;
    bcc_res_t   res0;
    bcc_res_t   res1;
  } bcc_push_t;

endpackage

`default_nettype wire

// ===== design/bcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// APB register file holding the debounce, long press and double click times.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output bcc_cfg_t         cfg_o
);

  bcc_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_time <= DEBOUNCE_RST;
      cfg_q.long_limit  <= LONG_RST;
      cfg_q.pair_window <= DOUBLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE: cfg_q.settle_time <= pwdata[CFG_W-1:0];
        REG_LONG:     cfg_q.long_limit  <= pwdata[CFG_W-1:0];
        REG_DOUBLE:   cfg_q.pair_window <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE: prdata = {16'd0, cfg_q.settle_time};
      REG_LONG:     prdata = {16'd0, cfg_q.long_limit};
      REG_DOUBLE:   prdata = {16'd0, cfg_q.pair_window};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/bcc_core.sv =====
// ----------------------------------------------------------------------------
// bcc_core
// Input register, per-button state and the edge classification logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_core
  import bcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bcc_cfg_t          cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_button_i,
  input  wire logic              in_pressed_i,
  input  wire logic [TIME_W-1:0] in_time_i,
  input  wire logic              room_i,
  output bcc_push_t              push_o
);

  logic              in_v_q;
  logic              btn_q;
  logic              pr_q;
  logic [TIME_W-1:0] now_q;

  logic [NUM_BUTTONS-1:0] down_q, down_d;
  logic [NUM_BUTTONS-1:0] pend_q, pend_d;
  logic [TIME_W-1:0]      press_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      rel_q   [NUM_BUTTONS];

  logic              proceed;
  logic              in_range;
  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] hold;
  logic [TIME_W-1:0] gap;
  logic              take;
  logic              press_ok;
  logic              rel_ok;
  logic [KIND_W-1:0] kind;

  assign proceed    = in_v_q && room_i;
  assign in_ready_o = !in_v_q || proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      btn_q <= in_button_i;
      pr_q  <= in_pressed_i;
      now_q <= in_time_i;
    end
  end

  assign in_range = {31'd0, btn_q} < NUM_BUTTONS;
  assign since    = now_q - (pr_q ? rel_q[btn_q] : press_q[btn_q]);
  assign hold     = now_q - press_q[btn_q];
  assign gap      = now_q - rel_q[btn_q];
  assign take     = proceed && in_range && (since >= {16'd0, cfg_i.settle_time});
  assign press_ok = take && pr_q && !down_q[btn_q];
  assign rel_ok   = take && !pr_q && down_q[btn_q];

  always_comb begin
    down_d = down_q;
    pend_d = pend_q;
    priority if (hold >= {16'd0, cfg_i.long_limit}) begin
      kind = KIND_LONG;
    end else if (pend_q[btn_q] && (gap < {16'd0, cfg_i.pair_window})) begin
      kind = KIND_DOUBLE;
    end else begin
      kind = KIND_CLICK;
    end
    if (press_ok) begin
      down_d[btn_q] = 1'b1;
    end
    if (rel_ok) begin
      down_d[btn_q] = 1'b0;
      if (kind == KIND_DOUBLE) begin
        pend_d[btn_q] = 1'b0;
      end else if (kind == KIND_CLICK) begin
        pend_d[btn_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= '0;
      pend_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_q[i] <= '0;
        rel_q[i]   <= '0;
      end
    end else begin
      down_q <= down_d;
      pend_q <= pend_d;
      if (press_ok) begin
        press_q[btn_q] <= now_q;
      end
      if (rel_ok) begin
        rel_q[btn_q] <= now_q;
      end
    end
  end

  always_comb begin
    push_o.num             = press_ok ? 2'd1 : (rel_ok ? 2'd2 : 2'd0);
    push_o.res0.button_res = btn_q;
    push_o.res0.event_kind = press_ok ? KIND_PRESSED : KIND_RELEASED;
    push_o.res0.hold_ms    = press_ok ? '0 : hold;
    push_o.res0.last       = press_ok;
    push_o.res1.button_res = btn_q;
    push_o.res1.event_kind = kind;
    push_o.res1.hold_ms    = hold;
    push_o.res1.last       = 1'b1;
  end

`ifndef SYNTHESIS
  a_no_push_without_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.num != 2'd0) |-> room_i)
    else $error("push without queue room");
  a_press_sets_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    press_ok |=> down_q[$past(btn_q)])
    else $error("press did not set down state");
  a_release_clears_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_ok |=> !down_q[$past(btn_q)])
    else $error("release did not clear down state");
`endif

endmodule

`default_nettype wire

// ===== design/bcc_out_queue.sv =====
// ----------------------------------------------------------------------------
// bcc_out_queue
// Small result queue taking up to two results a cycle, issuing one while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_out_queue
  import bcc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire bcc_push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output bcc_res_t       out_res_o
);

  bcc_res_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_q, tail_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;
  logic [QPTR_W-1:0] tail_p1;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = cnt_q <= QCNT_W'(QUEUE_DEPTH - 2);
  assign tail_p1     = tail_q + QPTR_W'(1);
  assign out_res_o   = mem_q[head_q];

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[tail_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[tail_p1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (pop) begin
        head_q <= head_q + QPTR_W'(1);
      end
      tail_q <= tail_q + QPTR_W'(push_i.num);
      cnt_q  <= cnt_q + QCNT_W'(push_i.num) - QCNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q - head_q) == cnt_q[QPTR_W-1:0])
    else $error("queue pointers disagree with count");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num == 2'd2) |-> (!push_i.res0.last && push_i.res1.last))
    else $error("release pair not marked correctly");
`endif

endmodule

`default_nettype wire

// ===== design/button_click_classifier.sv =====
// Flow: an accepted request is held in the input register, classified from there once the
// result queue has room, and its results are presented from the result queue.
// Throughput: one request per cycle while the result queue has room; a
// release yields two results over the one-result-per-cycle output, so
// a run of releases is held back until the queue drains.
// Reset: clears button state, stamps and the result queue, loads register defaults.
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounces button edges and reports press, release, click, double click
// and long press events.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier
  import bcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] time_ms
  input  wire logic [1:0]  s_axis_tuser,   // [0] button, [1] pressed
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [31:0] hold_ms
  output logic      [3:0]  m_axis_tuser,   // [0] button_res, [3:1] event_kind
  output logic             m_axis_tlast
);

  bcc_cfg_t  cfg;
  bcc_push_t push;
  bcc_res_t  res;
  logic      room;

  bcc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_button_i  (s_axis_tuser[0]),
    .in_pressed_i (s_axis_tuser[1]),
    .in_time_i    (s_axis_tdata),
    .room_i       (room),
    .push_o       (push)
  );

  bcc_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = res.hold_ms;
  assign m_axis_tuser = {res.event_kind, res.button_res};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
